@@ src/slac_pkg.sv @@
// Shared types, constants and helpers for the set-associative LRU cache model.
// No dependencies; the design modules and the checker import this package.
package slac_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int NUM_SETS     = 1 << MAX_SET_BITS;
	localparam int TAG_W        = 62;
	localparam int RANK_W       = $clog2(MAX_WAYS);
	localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int MAX_BLOCK    = 56;
	localparam int QUEUE_DEPTH  = 2;

	// request kinds
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// lookup outcomes
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_MISS  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	typedef logic [MAX_SET_BITS-1:0] set_idx_t;
	typedef logic [TAG_W-1:0]        tag_t;
	typedef logic [RANK_W-1:0]       rank_t;

	// clamped geometry
	typedef struct packed {
		logic [2:0] set_bits;
		logic [5:0] block_bits;
		logic [3:0] ways;
	} geom_t;

	// one queued lookup job
	typedef struct packed {
		set_idx_t set_idx;
		tag_t     tag;
		logic     modify;
	} job_t;

	// one set row kept in the tag memory: valid bits, tags and ranks
	typedef struct packed {
		logic  [MAX_WAYS-1:0] valid;
		tag_t  [MAX_WAYS-1:0] tag;
		rank_t [MAX_WAYS-1:0] rank;
	} row_t;

	function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi);
		logic [6:0] r;
		r = v;
		if (v < lo) r = lo;
		if (v > hi) r = hi;
		return r;
	endfunction

endpackage

@@ src/slac_if.sv @@
// Valid/ready channel interfaces for requests and lookup results.
// Uses slac_pkg for nothing but is compiled after it.
interface slac_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] address;
	modport source (output valid, req_type, address, input ready);
	modport sink   (input valid, req_type, address, output ready);
endinterface

interface slac_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic        last;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] eviction_count;
	modport source (output valid, outcome, last, hit_count, miss_count, eviction_count,
		input ready);
	modport sink   (input valid, outcome, last, hit_count, miss_count, eviction_count,
		output ready);
endinterface

@@ src/slac_front.sv @@
// Front end: accepts requests, drops unknown kinds, splits address into set and tag.
// Depends on slac_pkg and slac_req_if.
module slac_front (
	slac_req_if.sink        req,
	input  slac_pkg::geom_t geom,
	output logic            push_valid,
	output slac_pkg::job_t  push_job,
	input  logic            push_ready
);
	import slac_pkg::*;

	logic [6:0]  sb_sum;
	logic [6:0]  idx_mask;
	logic [63:0] set_shift;
	logic [63:0] tag_shift;

	// unknown kinds are taken and dropped
	assign req.ready  = push_ready;
	assign push_valid = req.valid && (req.req_type != REQ_NONE);

	// address split
	always_comb begin
		sb_sum    = 7'(geom.set_bits) + 7'(geom.block_bits);
		idx_mask  = (7'd1 << geom.set_bits) - 7'd1;
		set_shift = req.address >> geom.block_bits;
		tag_shift = req.address >> sb_sum;
		push_job.set_idx = set_idx_t'(set_shift[MAX_SET_BITS-1:0] & idx_mask[MAX_SET_BITS-1:0]);
		push_job.tag     = (sb_sum >= 7'd64) ? '0 : tag_shift[TAG_W-1:0];
		push_job.modify  = (req.req_type == REQ_MODIFY);
	end

endmodule

@@ src/slac_queue.sv @@
// Short job queue between front and back end.
// Depends on slac_pkg.
module slac_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  slac_pkg::job_t push_job,
	output logic           push_ready,
	input  logic           pop,
	output logic           head_valid,
	output slac_pkg::job_t head_job
);
	import slac_pkg::*;

	job_t       entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;

	assign push_ready = (count_q != 2'(QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_job   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ src/slac_back.sv @@
// Back end: reads a set row, resolves hit/fill/evict, updates LRU ranks and counters.
// Depends on slac_pkg and slac_rsp_if.
module slac_back (
	input  logic            clk,
	input  logic            arst_n,
	input  slac_pkg::geom_t geom,
	input  logic            head_valid,
	input  slac_pkg::job_t  head_job,
	output logic            pop,
	slac_rsp_if.source      rsp
);
	import slac_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t                state_q;
	set_idx_t              clr_q;
	row_t                  mem [NUM_SETS];
	row_t                  rdata_q;
	row_t                  fwd_q;
	logic                  use_fwd_q;
	logic                  second_q;
	job_t                  job_q;

	logic                  out_valid_q;
	logic [1:0]            outcome_q;
	logic                  last_q;
	logic [31:0]           hits_q;
	logic [31:0]           misses_q;
	logic [31:0]           evicts_q;

	row_t                  cur_row;
	row_t                  new_row;
	logic [MAX_WAYS-1:0]   vld;
	logic [MAX_WAYS-1:0]   in_use;
	logic                  hit;
	logic                  has_empty;
	logic [WAY_W-1:0]      hit_way;
	logic [WAY_W-1:0]      empty_way;
	logic [WAY_W-1:0]      lru_way;
	logic [WAY_W-1:0]      use_way;
	rank_t                 best;
	logic [RANK_W:0]       old_rank;
	logic [1:0]            outcome;
	logic                  step;
	logic                  is_last;

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign step     = (state_q == ST_LOOK) && (!out_valid_q || rsp.ready);
	assign is_last  = !(job_q.modify && !second_q);
	assign cur_row  = use_fwd_q ? fwd_q : rdata_q;
	assign vld      = cur_row.valid;

	// lookup decision and rank update
	always_comb begin
		hit       = 1'b0;
		has_empty = 1'b0;
		hit_way   = '0;
		empty_way = '0;
		lru_way   = '0;
		best      = cur_row.rank[0];
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = (4'(i) < geom.ways);
		end
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (in_use[i] && vld[i] && (cur_row.tag[i] == job_q.tag)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (in_use[i] && !vld[i]) begin
				has_empty = 1'b1;
				empty_way = WAY_W'(i);
			end
		end
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && (cur_row.rank[i] > best)) begin
				best    = cur_row.rank[i];
				lru_way = WAY_W'(i);
			end
		end
		if (hit) begin
			use_way  = hit_way;
			old_rank = {1'b0, cur_row.rank[hit_way]};
			outcome  = OUT_HIT;
		end else if (has_empty) begin
			use_way  = empty_way;
			old_rank = (RANK_W+1)'(MAX_WAYS);
			outcome  = OUT_MISS;
		end else begin
			use_way  = lru_way;
			old_rank = {1'b0, cur_row.rank[lru_way]};
			outcome  = OUT_EVICT;
		end
		new_row = cur_row;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use[i] && vld[i] && (WAY_W'(i) != use_way)
					&& ({1'b0, cur_row.rank[i]} < old_rank)
					&& (cur_row.rank[i] != rank_t'(MAX_WAYS - 1))) begin
				new_row.rank[i] = cur_row.rank[i] + rank_t'(1);
			end
		end
		new_row.rank[use_way]  = '0;
		new_row.tag[use_way]   = job_q.tag;
		new_row.valid[use_way] = 1'b1;
	end

	// sequencer, counters, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			use_fwd_q   <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
		end else begin
			if (step) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + set_idx_t'(1);
					if (clr_q == set_idx_t'(NUM_SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						state_q   <= ST_LOOK;
						use_fwd_q <= 1'b0;
						second_q  <= 1'b0;
					end
				end
				ST_LOOK: begin
					if (step) begin
						if (outcome == OUT_HIT) begin
							if (hits_q != '1) hits_q <= hits_q + 32'd1;
						end else begin
							if (misses_q != '1) misses_q <= misses_q + 32'd1;
						end
						if (outcome == OUT_EVICT && evicts_q != '1)
							evicts_q <= evicts_q + 32'd1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							use_fwd_q <= 1'b1;
							second_q  <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) job_q <= head_job;
		if (step) begin
			fwd_q     <= new_row;
			outcome_q <= outcome;
			last_q    <= is_last;
		end
	end

	// tag, rank and valid memory; cleared row by row after reset
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[clr_q] <= '0;
		else if (step) mem[job_q.set_idx] <= new_row;
		if (pop) rdata_q <= mem[head_job.set_idx];
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.outcome        = outcome_q;
	assign rsp.last           = last_q;
	assign rsp.hit_count      = hits_q;
	assign rsp.miss_count     = misses_q;
	assign rsp.eviction_count = evicts_q;

endmodule

@@ src/set_assoc_lru_cache_model.sv @@
// Tag-only set-associative cache with LRU replacement; load/store one lookup, modify two.
// A request passes the queue, then a pop with row read, then compare and write-back into the
// result register; a modify's second result comes from the updated row.
// The back end takes no new request until all lookups of the current one are done.
// Reset: clears counters, queue and registers (geometry 1,1,1), then a clearing pass over all 64
// rows of the row memory before the first lookup. Depends on slac_pkg, slac_if, front/queue/back.
module set_assoc_lru_cache_model (
	input  logic       clk,
	input  logic       arst_n,
	slac_req_if.sink   req,
	slac_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_wdata
);
	import slac_pkg::*;

	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;
	geom_t      geom;
	logic       push_valid;
	job_t       push_job;
	logic       push_ready;
	logic       head_valid;
	job_t       head_job;
	logic       pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd1;
			block_bits_q <= 6'd1;
			ways_q       <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_wdata[2:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_wdata;
				REG_WAYS:       ways_q       <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// clamp into legal geometry
	always_comb begin
		geom.set_bits   = 3'(clamp7(7'(set_bits_q), 7'd1, 7'(MAX_SET_BITS)));
		geom.block_bits = 6'(clamp7(7'(block_bits_q), 7'd1, 7'(MAX_BLOCK)));
		geom.ways       = 4'(clamp7(7'(ways_q), 7'd1, 7'(MAX_WAYS)));
	end

	slac_front u_front (
		.req        (req),
		.geom       (geom),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	slac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	slac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

@@ src/slac_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
// Depends on slac_pkg and set_assoc_lru_cache_model.
module slac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  outcome,
	input logic        last,
	input logic [31:0] hit_count,
	input logic [31:0] miss_count
);
	import slac_pkg::*;

	logic        second_due_q;
	logic        seen_q;
	logic [31:0] prev_hits_q;
	logic [31:0] prev_misses_q;

	// track what the last transaction showed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_due_q  <= 1'b0;
			seen_q        <= 1'b0;
			prev_hits_q   <= '0;
			prev_misses_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			second_due_q  <= !last;
			seen_q        <= 1'b1;
			prev_hits_q   <= hit_count;
			prev_misses_q <= miss_count;
		end
	end

	// second lookup of a modify always hits and closes the request
	a_modify_second_hits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && second_due_q |-> (outcome == OUT_HIT) && last)
		else $error("second modify lookup did not hit");

	// counters never go backwards
	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_q |-> (hit_count >= prev_hits_q) && (miss_count >= prev_misses_q))
		else $error("counter decreased");

	// exactly one lookup counted per transaction, below saturation
	a_one_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_q && (prev_hits_q != '1) && (prev_misses_q != '1)
		|-> ((hit_count - prev_hits_q) + (miss_count - prev_misses_q)) == 32'd1)
		else $error("lookup count step wrong");

	// stalled result holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome) && $stable(hit_count))
		else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_model slac_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.outcome    (rsp.outcome),
	.last       (rsp.last),
	.hit_count  (rsp.hit_count),
	.miss_count (rsp.miss_count)
);
